// ===== hdl/slcd_pkg.sv =====
// Shared types, constants and glyph helpers for the segment LCD decimal renderer.
`timescale 1ns / 1ps
package slcd_pkg;

  localparam int unsigned IdxW    = 7;
  localparam int unsigned BinW    = 28;
  localparam int unsigned BcdW    = 32;
  localparam int unsigned Digits  = 8;
  localparam int unsigned StepsPerStage = 7;
  localparam logic [31:0] MaxPos  = 32'd99999999;
  localparam logic [31:0] MaxNeg  = 32'd9999999;
  localparam logic [1:0]  DotShift = 2'd1;
  localparam logic [1:0]  DotPad3  = 2'd2;
  localparam logic [IdxW-1:0] PointIdx = 7'd14;
  localparam logic [IdxW-1:0] BarBase  = 7'd56;

  // Item as it moves down the conversion pipeline.
  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
    logic [3:0]      pos0;
    logic            neg;
    logic [1:0]      dot;
  } item_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hFC;
      4'd1:    g = 8'h60;
      4'd2:    g = 8'hDA;
      4'd3:    g = 8'hF2;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'hB6;
      4'd6:    g = 8'hBE;
      4'd7:    g = 8'hE0;
      4'd8:    g = 8'hFE;
      4'd9:    g = 8'hF6;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Row base (swapped common times 28) for segments A..G.
  function automatic logic [IdxW-1:0] seg_base(input logic [2:0] k);
    logic [IdxW-1:0] b;
    case (k)
      3'd0:    b = 7'd84;
      3'd1:    b = 7'd56;
      3'd2:    b = 7'd28;
      3'd3:    b = 7'd0;
      3'd4:    b = 7'd28;
      3'd5:    b = 7'd84;
      3'd6:    b = 7'd56;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

  // Segments A..D sit in the odd column of a position.
  function automatic logic seg_odd(input logic [2:0] k);
    return (k <= 3'd3);
  endfunction

endpackage

// ===== hdl/slcd_in_if.sv =====
// Request channel: value, rightmost position and point mode.
`timescale 1ns / 1ps
interface slcd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  end_position;
  logic signed [31:0] value;
  logic [1:0]  dot_mode;

  modport source (output valid, end_position, value, dot_mode, input ready);
  modport sink (input valid, end_position, value, dot_mode, output ready);
endinterface

// ===== hdl/slcd_out_if.sv =====
// Result channel: single segment memory bit writes.
`timescale 1ns / 1ps
interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] bit_index;
  logic       bit_value;
  logic       last;

  modport source (output valid, bit_index, bit_value, last, input ready);
  modport sink (input valid, bit_index, bit_value, last, output ready);
endinterface

// ===== hdl/slcd_front.sv =====
// Input stage: range checks, sign split and magnitude.
`timescale 1ns / 1ps
module slcd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [3:0]           end_position_i,
  input  logic [31:0]          value_i,
  input  logic [1:0]           dot_mode_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output slcd_pkg::item_t      item_o
);

  logic            valid_q;
  slcd_pkg::item_t item_q, item_d;
  logic            neg, ok;
  logic [31:0]     mag;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    neg = value_i[31];
    mag = neg ? (32'd0 - value_i) : value_i;
    ok  = (end_position_i >= 4'd1) && (end_position_i <= 4'd8) &&
          (neg ? (mag <= slcd_pkg::MaxNeg) : (mag <= slcd_pkg::MaxPos));
    item_d.bcd  = '0;
    item_d.bin  = mag[slcd_pkg::BinW-1:0];
    item_d.pos0 = (dot_mode_i == slcd_pkg::DotShift) ? end_position_i - 4'd1
                                                      : end_position_i;
    item_d.neg  = neg;
    item_d.dot  = dot_mode_i;
  end

  // Drop rejected requests here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/slcd_bcd_stage.sv =====
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
module slcd_bcd_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  slcd_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output slcd_pkg::item_t item_o
);

  logic            valid_q;
  slcd_pkg::item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    item_d = item_i;
    for (int s = 0; s < slcd_pkg::StepsPerStage; s++) begin
      for (int d = 0; d < slcd_pkg::Digits; d++) begin
        if (item_d.bcd[4*d +: 4] >= 4'd5) begin
          item_d.bcd[4*d +: 4] = item_d.bcd[4*d +: 4] + 4'd3;
        end
      end
      item_d.bcd = {item_d.bcd[slcd_pkg::BcdW-2:0], item_d.bin[slcd_pkg::BinW-1]};
      item_d.bin = {item_d.bin[slcd_pkg::BinW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/slcd_serial.sv =====
// Plans one converted item and emits its bit writes one per cycle unless wr_o stalls.
`timescale 1ns / 1ps
module slcd_serial (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  slcd_pkg::item_t item_i,
  slcd_out_if.source      wr_o
);

  logic [slcd_pkg::BcdW-1:0] bcd_q;
  logic [3:0] pos0_q, ndv_q, npre_q, u_q;
  logic [2:0] k_q;
  logic       has_pt_q, ptd_q;
  logic [6:0] bar_idx_q;
  logic [5:0] rem_q;
  logic       out_valid_q;
  logic [6:0] out_idx_q;
  logic       out_val_q, out_last_q;

  logic [3:0] nd, padlen, ndig, ndv, npre, barpos;
  logic       has_pt, has_bar;
  logic [5:0] tot;
  logic       busy, emit, load, is_pt, is_dig;
  logic [3:0] p, dig;
  logic [7:0] g;
  logic [6:0] idx_d;
  logic       val_d;

  assign busy    = (rem_q != 6'd0);
  assign ready_o = !busy;
  assign load    = valid_i && !busy;
  assign emit    = busy && (!out_valid_q || wr_o.ready);

  // Plan the write sequence of a new item.
  always_comb begin
    nd = 4'd0;
    for (int i = 0; i < slcd_pkg::Digits; i++) begin
      if (item_i.bcd[4*i +: 4] != 4'd0) begin
        nd = 4'(i + 1);
      end
    end
    has_pt  = (item_i.dot == slcd_pkg::DotShift) || (item_i.dot == slcd_pkg::DotPad3);
    padlen  = (item_i.dot == slcd_pkg::DotPad3) ? 4'd3 :
              (item_i.dot == slcd_pkg::DotShift) ? 4'd2 : 4'd1;
    ndig    = (nd > padlen) ? nd : padlen;
    ndv     = (ndig < item_i.pos0) ? ndig : item_i.pos0;
    npre    = (nd < ndv) ? nd : ndv;
    has_bar = item_i.neg && (item_i.pos0 >= ndig);
    barpos  = item_i.pos0 - ndig;
    tot     = 6'(ndv) * 6'd7 + 6'(has_pt) + 6'(has_bar);
  end

  // Current write of the item in progress.
  always_comb begin
    is_pt  = has_pt_q && !ptd_q && (u_q == npre_q);
    is_dig = !is_pt && (u_q < ndv_q);
    p      = pos0_q - u_q;
    dig    = bcd_q[4*u_q[2:0] +: 4];
    g      = slcd_pkg::glyph(dig);
    if (is_pt) begin
      idx_d = slcd_pkg::PointIdx;
      val_d = 1'b1;
    end else if (is_dig) begin
      idx_d = slcd_pkg::seg_base(k_q) + 7'({p, slcd_pkg::seg_odd(k_q)});
      val_d = g[3'd7 - k_q];
    end else begin
      idx_d = bar_idx_q;
      val_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      u_q         <= '0;
      k_q         <= '0;
      ptd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        rem_q <= tot;
        u_q   <= '0;
        k_q   <= '0;
        ptd_q <= 1'b0;
      end else if (emit) begin
        rem_q <= rem_q - 6'd1;
        if (is_pt) begin
          ptd_q <= 1'b1;
        end else if (is_dig) begin
          if (k_q == 3'd6) begin
            k_q <= '0;
            u_q <= u_q + 4'd1;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (wr_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q     <= item_i.bcd;
      pos0_q    <= item_i.pos0;
      ndv_q     <= ndv;
      npre_q    <= npre;
      has_pt_q  <= has_pt;
      bar_idx_q <= slcd_pkg::BarBase + 7'({barpos, 1'b0});
    end
    if (emit) begin
      out_idx_q  <= idx_d;
      out_val_q  <= val_d;
      out_last_q <= (rem_q == 6'd1);
    end
  end

  assign wr_o.valid     = out_valid_q;
  assign wr_o.bit_index = out_idx_q;
  assign wr_o.bit_value = out_val_q;
  assign wr_o.last      = out_last_q;

endmodule

// ===== hdl/segment_lcd_decimal_renderer.sv =====
// Top level of the segment LCD decimal renderer.
// Usage:
//   req_i carries one request: a signed value, the rightmost digit position
//   (1..8) and a point mode. Bad positions and out-of-range values are
//   dropped without any write.
//   wr_o carries the resulting segment memory bit writes, one per cycle
//   while wr_o is ready, with last set on the final write of each request
//   (up to 57 writes). Path: a request is registered by the input stage at
//   the edge that accepts it, then passes four BCD stages, the plan load and
//   the output register before its first write appears.
//   Throughput: the pipeline takes a request every cycle unless stalled;
//   the serializer takes a new request only once the current one is done,
//   so the sustained rate is set by the single write port of wr_o.
//   Reset clears all valid bits; no write is pending after reset.
//   When wr_o stalls the current write holds, the serializer and pipeline
//   fill up, and req_i drops ready once every stage is occupied.
`timescale 1ns / 1ps
module segment_lcd_decimal_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_in_if.sink     req_i,
  slcd_out_if.source  wr_o
);

  localparam int unsigned NStages = 4;

  logic            v [NStages+1];
  logic            r [NStages+1];
  slcd_pkg::item_t it [NStages+1];

  slcd_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i        (req_i.valid),
    .ready_o        (req_i.ready),
    .end_position_i (req_i.end_position),
    .value_i        (req_i.value),
    .dot_mode_i     (req_i.dot_mode),
    .valid_o        (v[0]),
    .ready_i        (r[0]),
    .item_o         (it[0])
  );

  for (genvar s = 0; s < NStages; s++) begin : g_bcd
    slcd_bcd_stage u_stage (
      .clk_i,
      .rst_ni,
      .valid_i (v[s]),
      .ready_o (r[s]),
      .item_i  (it[s]),
      .valid_o (v[s+1]),
      .ready_i (r[s+1]),
      .item_o  (it[s+1])
    );
  end

  slcd_serial u_serial (
    .clk_i,
    .rst_ni,
    .valid_i (v[NStages]),
    .ready_o (r[NStages]),
    .item_i  (it[NStages]),
    .wr_o    (wr_o)
  );

endmodule

// ===== hdl/slcd_chk.sv =====
// Port-level checks for the segment LCD decimal renderer.
`timescale 1ns / 1ps
module slcd_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_index_i,
  input logic       out_value_i
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("write shown during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("write withdrawn under stall");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_index_i <= 7'd111)
    else $error("bit index out of range");

  a_point_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_index_i == 7'd14 |-> out_value_i)
    else $error("point symbol cleared");

endmodule

bind segment_lcd_decimal_renderer slcd_chk u_slcd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (wr_o.valid),
  .out_ready_i (wr_o.ready),
  .out_index_i (wr_o.bit_index),
  .out_value_i (wr_o.bit_value)
);
